// ===== hdl/emgt_pkg.sv =====
`timescale 1ns / 1ps

package emgt_pkg;

    // default build widths
    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int RUN_BITS_DEF      = 8;

    // register file widths
    localparam int LEVEL_CFG_W = 12;
    localparam int GAIN_W      = 16;
    localparam int COUNT_CFG_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;

    // gain is q1.15
    localparam int GAIN_FRAC = 15;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

    // register reset values
    localparam logic [LEVEL_CFG_W-1:0] TRIGGER_LEVEL_RST      = 12'd2200;
    localparam logic [LEVEL_CFG_W-1:0] RELEASE_LEVEL_RST      = 12'd1800;
    localparam logic [GAIN_W-1:0]      SMOOTHING_GAIN_RST     = 16'd3277;
    localparam logic [COUNT_CFG_W-1:0] SAMPLES_TO_TRIGGER_RST = 8'd2;
    localparam logic [COUNT_CFG_W-1:0] SAMPLES_TO_RELEASE_RST = 8'd3;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_START  = 2'd1,
        KIND_STOP   = 2'd2
    } emgt_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_LEVEL      = 3'd0,
        REG_RELEASE_LEVEL      = 3'd1,
        REG_SMOOTHING_GAIN     = 3'd2,
        REG_SAMPLES_TO_TRIGGER = 3'd3,
        REG_SAMPLES_TO_RELEASE = 3'd4
    } emgt_reg_t;

    typedef struct packed {
        logic [LEVEL_CFG_W-1:0] trigger_level;
        logic [LEVEL_CFG_W-1:0] release_level;
        logic [GAIN_W-1:0]      smoothing_gain;
        logic [COUNT_CFG_W-1:0] samples_to_trigger;
        logic [COUNT_CFG_W-1:0] samples_to_release;
    } emgt_cfg_t;

endpackage

// ===== hdl/emgt_if.sv =====
`timescale 1ns / 1ps

interface emgt_item_if
    import emgt_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface emgt_result_if
    import emgt_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic [SAMPLE_BITS-1:0]               raw_echo;
    logic [SAMPLE_BITS+FRACTION_BITS-1:0] smoothed_level;
    logic                                 active;

    modport source (output valid, output raw_echo, output smoothed_level, output active,
                    input ready);
    modport sink   (input valid, input raw_echo, input smoothed_level, input active,
                    output ready);
endinterface

// ===== hdl/emgt_cfg.sv =====
`timescale 1ns / 1ps

module emgt_cfg
    import emgt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output emgt_cfg_t             cfg
);

    emgt_cfg_t cfg_reg;
    emgt_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (emgt_reg_t'(cfg_index))
                REG_TRIGGER_LEVEL:      cfg_next.trigger_level = cfg_wdata[LEVEL_CFG_W-1:0];
                REG_RELEASE_LEVEL:      cfg_next.release_level = cfg_wdata[LEVEL_CFG_W-1:0];
                REG_SMOOTHING_GAIN:     cfg_next.smoothing_gain = cfg_wdata[GAIN_W-1:0];
                REG_SAMPLES_TO_TRIGGER:
                    cfg_next.samples_to_trigger = cfg_wdata[COUNT_CFG_W-1:0];
                REG_SAMPLES_TO_RELEASE:
                    cfg_next.samples_to_release = cfg_wdata[COUNT_CFG_W-1:0];
                // unmapped index, write ignored
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_level      <= TRIGGER_LEVEL_RST;
            cfg_reg.release_level      <= RELEASE_LEVEL_RST;
            cfg_reg.smoothing_gain     <= SMOOTHING_GAIN_RST;
            cfg_reg.samples_to_trigger <= SAMPLES_TO_TRIGGER_RST;
            cfg_reg.samples_to_release <= SAMPLES_TO_RELEASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/emgt_core.sv =====
`timescale 1ns / 1ps

module emgt_core
    import emgt_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int RUN_BITS      = RUN_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  emgt_kind_t                           kind,
    input  logic [SAMPLE_BITS-1:0]               sample,
    input  emgt_cfg_t                            cfg,
    output logic                                 produce,
    output logic [SAMPLE_BITS+FRACTION_BITS-1:0] level_new,
    output logic                                 fired_new
);

    localparam int LEVEL_W = SAMPLE_BITS + FRACTION_BITS;
    localparam int DIFF_W  = LEVEL_W + 1;
    localparam int PROD_W  = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int THR_W   = LEVEL_CFG_W + FRACTION_BITS;
    localparam int CMP_W   = (LEVEL_W > THR_W) ? LEVEL_W : THR_W;
    localparam int CNT_W   = (RUN_BITS > COUNT_CFG_W) ? RUN_BITS : COUNT_CFG_W;
    localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

    logic                running_reg;
    logic                running_next;
    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  level_next;
    logic [RUN_BITS-1:0] above_run_reg;
    logic [RUN_BITS-1:0] above_run_next;
    logic [RUN_BITS-1:0] below_run_reg;
    logic [RUN_BITS-1:0] below_run_next;
    logic                fired_reg;
    logic                fired_next;

    logic [GAIN_W-1:0]        gain;
    logic [LEVEL_W-1:0]       scaled;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  base;
    logic signed [SUM_W-1:0]  sum;
    logic [CMP_W-1:0]         level_cmp;
    logic [CMP_W-1:0]         trig_cmp;
    logic [CMP_W-1:0]         rel_cmp;
    logic [RUN_BITS-1:0]      above_inc;
    logic [RUN_BITS-1:0]      below_inc;
    logic [RUN_BITS-1:0]      above_new;
    logic [RUN_BITS-1:0]      below_new;

    // level + g*(s - level), floored; equals the blended form exactly
    always_comb
    begin
        gain   = (cfg.smoothing_gain > GAIN_ONE) ? GAIN_ONE : cfg.smoothing_gain;
        scaled = {sample, {FRACTION_BITS{1'b0}}};
        diff   = $signed({1'b0, scaled}) - $signed({1'b0, level_reg});
        prod   = $signed({1'b0, gain}) * diff;
        base   = SUM_W'($signed({1'b0, level_reg, {GAIN_FRAC{1'b0}}}));
        sum    = base + SUM_W'(prod);
        level_new = sum[GAIN_FRAC +: LEVEL_W];
    end

    // hysteresis band and run counters
    always_comb
    begin
        level_cmp = CMP_W'(level_new);
        trig_cmp  = CMP_W'({cfg.trigger_level, {FRACTION_BITS{1'b0}}});
        rel_cmp   = CMP_W'({cfg.release_level, {FRACTION_BITS{1'b0}}});
        above_inc = (above_run_reg == RUN_MAX) ? RUN_MAX : above_run_reg + 1'b1;
        below_inc = (below_run_reg == RUN_MAX) ? RUN_MAX : below_run_reg + 1'b1;
        if (level_cmp >= trig_cmp)
        begin
            above_new = above_inc;
            below_new = '0;
        end
        else if (level_cmp <= rel_cmp)
        begin
            above_new = '0;
            below_new = below_inc;
        end
        else
        begin
            above_new = '0;
            below_new = '0;
        end

        if (!fired_reg && (CNT_W'(above_new) >= CNT_W'(cfg.samples_to_trigger)))
            fired_new = 1'b1;
        else if (fired_reg && (CNT_W'(below_new) >= CNT_W'(cfg.samples_to_release)))
            fired_new = 1'b0;
        else
            fired_new = fired_reg;
    end

    assign produce = (kind == KIND_SAMPLE) && running_reg;

    always_comb
    begin
        running_next   = running_reg;
        level_next     = level_reg;
        above_run_next = above_run_reg;
        below_run_next = below_run_reg;
        fired_next     = fired_reg;
        if (step)
        begin
            unique case (kind)
                KIND_START:
                begin
                    running_next   = 1'b1;
                    above_run_next = '0;
                    below_run_next = '0;
                    fired_next     = 1'b0;
                end
                KIND_STOP:
                begin
                    running_next   = 1'b0;
                    above_run_next = '0;
                    below_run_next = '0;
                    fired_next     = 1'b0;
                end
                KIND_SAMPLE:
                begin
                    if (running_reg)
                    begin
                        level_next     = level_new;
                        above_run_next = above_new;
                        below_run_next = below_new;
                        fired_next     = fired_new;
                    end
                end
                // reserved kind, no effect
                default:
                begin
                    running_next = running_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            level_reg     <= '0;
            above_run_reg <= '0;
            below_run_reg <= '0;
            fired_reg     <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            level_reg     <= level_next;
            above_run_reg <= above_run_next;
            below_run_reg <= below_run_next;
            fired_reg     <= fired_next;
        end
    end

endmodule

// ===== hdl/emg_envelope_trigger.sv =====
`timescale 1ns / 1ps
// pipeline: a sample transaction is held in the input register, then moves to the result register
// when the result register is free or being drained
// throughput: one transaction per cycle while the result side is not stalled; the filter update,
// thresholds and counters are combinational between the input register and the result register
// reset: rst_n asynchronous active low; stopped, level zero, counters and flag clear,
// registers back to their default values, both pipeline stages empty

module emg_envelope_trigger
    import emgt_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int RUN_BITS      = RUN_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    emgt_item_if.sink             item,
    emgt_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int LEVEL_W = SAMPLE_BITS + FRACTION_BITS;

    emgt_cfg_t cfg;

    // input stage
    logic                   in_valid_reg;
    logic                   in_valid_next;
    emgt_kind_t             in_kind_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    // result stage
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] out_raw_reg;
    logic [LEVEL_W-1:0]     out_level_reg;
    logic                   out_active_reg;

    logic               advance;
    logic               step;
    logic               item_take;
    logic               produce;
    logic [LEVEL_W-1:0] level_new;
    logic               fired_new;

    emgt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    emgt_core #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .RUN_BITS      (RUN_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .kind      (in_kind_reg),
        .sample    (in_sample_reg),
        .cfg       (cfg),
        .produce   (produce),
        .level_new (level_new),
        .fired_new (fired_new)
    );

    // the pipe moves whenever the result register is empty or being drained
    assign advance    = !out_valid_reg || result.ready;
    // the input register frees as soon as its item is processed
    assign item.ready = !in_valid_reg || advance;
    assign item_take  = item.valid && item.ready;
    // state update happens when the held transaction moves on
    assign step       = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item.ready)
            in_valid_next = item.valid;
    end

    // only samples taken while running leave a result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = step && produce;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_kind_reg   <= emgt_kind_t'(item.kind);
            in_sample_reg <= item.sample;
        end
        if (step && produce)
        begin
            out_raw_reg    <= in_sample_reg;
            out_level_reg  <= level_new;
            out_active_reg <= fired_new;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.raw_echo       = out_raw_reg;
    assign result.smoothed_level = out_level_reg;
    assign result.active         = out_active_reg;

endmodule

// ===== hdl/emgt_checker.sv =====
`timescale 1ns / 1ps

module emgt_checker
    import emgt_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 item_valid,
    input logic                                 item_ready,
    input logic [1:0]                           item_kind,
    input logic [SAMPLE_BITS-1:0]               item_sample,
    input logic                                 result_valid,
    input logic                                 result_ready,
    input logic [SAMPLE_BITS-1:0]               result_raw_echo,
    input logic [SAMPLE_BITS+FRACTION_BITS-1:0] result_smoothed_level,
    input logic                                 result_active
);

    // stalled result holds still
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_raw_echo)
            && $stable(result_smoothed_level) && $stable(result_active))
        else $error("result changed while stalled");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty result register");

    // a fresh result traces back to an accepted sample transaction
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready && item_kind == KIND_SAMPLE, 2))
        else $error("result without a matching sample transaction");

    a_result_echo: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> result_raw_echo == $past(item_sample, 2))
        else $error("raw echo does not match accepted sample");

endmodule

bind emg_envelope_trigger emgt_checker #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .item_valid            (item.valid),
    .item_ready            (item.ready),
    .item_kind             (item.kind),
    .item_sample           (item.sample),
    .result_valid          (result.valid),
    .result_ready          (result.ready),
    .result_raw_echo       (result.raw_echo),
    .result_smoothed_level (result.smoothed_level),
    .result_active         (result.active)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import emgt_pkg::*;

    // widths of the default build
    localparam int SB = SAMPLE_BITS_DEF;
    localparam int FB = FRACTION_BITS_DEF;
    localparam int RB = RUN_BITS_DEF;
    localparam int LW = SB + FB;

    // codes outside the package lists: the spare kind and two unused register slots
    localparam logic [1:0]           KIND_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // run shape
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 4;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [SB-1:0] raw;
        logic [LW-1:0] level;
        logic          active;
    } level_report_t;

    // one line of the directed script: either a register write or an input transaction,
    // the latter optionally with a hand-worked result
    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [1:0]            kind;
        logic [SB-1:0]         sample;
        logic                  typed;
        level_report_t         want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    emgt_item_if   item_ch ();
    emgt_result_if result_ch ();

    emg_envelope_trigger i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // register copies held by the predictor
    logic [LEVEL_CFG_W-1:0] trigger_q;
    logic [LEVEL_CFG_W-1:0] release_q;
    logic [GAIN_W-1:0]      gain_q;
    logic [COUNT_CFG_W-1:0] to_trigger_q;
    logic [COUNT_CFG_W-1:0] to_release_q;

    // envelope state held by the predictor
    logic          running_q;
    logic [LW-1:0] level_q;
    logic [RB-1:0] above_q;
    logic [RB-1:0] below_q;
    logic          fired_q;

    level_report_t level_reports_due[$];

    int errors = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;

    script_row_t directed_rows [34];

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void reset_envelope();
        trigger_q    = TRIGGER_LEVEL_RST;
        release_q    = RELEASE_LEVEL_RST;
        gain_q       = SMOOTHING_GAIN_RST;
        to_trigger_q = SAMPLES_TO_TRIGGER_RST;
        to_release_q = SAMPLES_TO_RELEASE_RST;
        running_q    = 1'b0;
        level_q      = '0;
        above_q      = '0;
        below_q      = '0;
        fired_q      = 1'b0;
    endfunction

    // one input transaction through the envelope follower; returns 1 when a
    // result transaction is due
    function automatic bit advance_envelope(input logic [1:0] kind, input logic [SB-1:0] raw,
                                            output level_report_t rep);
        longint unsigned gain_eff;
        longint unsigned scaled;
        longint unsigned acc;
        logic [LW-1:0]   trig_fx;
        logic [LW-1:0]   rel_fx;

        rep = '0;
        if (kind == KIND_START || kind == KIND_STOP)
        begin
            // start and stop both clear detection, the filter level is kept
            running_q = (kind == KIND_START);
            above_q   = '0;
            below_q   = '0;
            fired_q   = 1'b0;
            return 1'b0;
        end
        if (kind != KIND_SAMPLE || !running_q)
            return 1'b0;

        // gain above one acts as one
        gain_eff = (gain_q > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain_q);
        scaled   = 64'(raw);
        scaled   = scaled << FB;
        acc      = gain_eff * scaled + (longint'(GAIN_ONE) - gain_eff) * longint'(level_q);
        acc      = acc >> GAIN_FRAC;
        level_q  = acc[LW-1:0];

        trig_fx = {trigger_q, {FB{1'b0}}};
        rel_fx  = {release_q, {FB{1'b0}}};
        if (level_q >= trig_fx)
        begin
            above_q = (above_q == '1) ? above_q : above_q + 1'b1;
            below_q = '0;
        end
        else if (level_q <= rel_fx)
        begin
            below_q = (below_q == '1) ? below_q : below_q + 1'b1;
            above_q = '0;
        end
        else
        begin
            // band between the thresholds
            above_q = '0;
            below_q = '0;
        end

        if (!fired_q && above_q >= to_trigger_q)
            fired_q = 1'b1;
        else if (fired_q && below_q >= to_release_q)
            fired_q = 1'b0;

        rep.raw    = raw;
        rep.level  = level_q;
        rep.active = fired_q;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // directed script helpers
    // ------------------------------------------------------------------

    function automatic script_row_t item_row(input logic [1:0] kind, input logic [SB-1:0] sample);
        script_row_t row;
        row        = '0;
        row.kind   = kind;
        row.sample = sample;
        return row;
    endfunction

    function automatic script_row_t checked_row(input logic [SB-1:0] sample,
                                                input logic [LW-1:0] level,
                                                input logic active);
        script_row_t row;
        row             = item_row(KIND_SAMPLE, sample);
        row.typed       = 1'b1;
        row.want.raw    = sample;
        row.want.level  = level;
        row.want.active = active;
        return row;
    endfunction

    function automatic script_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_DATA_W-1:0] data);
        script_row_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.idx      = idx;
        row.data     = data;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // drivers; every task starts and ends just after a falling edge
    // ------------------------------------------------------------------

    // offer one input transaction, wait for it to be taken and log what it should produce
    task automatic send_item(input logic [1:0] kind, input logic [SB-1:0] sample,
                             input bit typed, input level_report_t want);
        level_report_t rep;
        bit            due;

        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid  = 1'b1;
        item_ch.kind   = kind;
        item_ch.sample = sample;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        due = advance_envelope(kind, sample, rep);
        if (due)
            level_reports_due.push_back(typed ? want : rep);
        @(negedge clk);
    endtask

    // input side quiet, every result in, then a settling wait for anything still in flight
    task automatic drain_results();
        item_ch.valid = 1'b0;
        while (level_reports_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_TRIGGER_LEVEL:      trigger_q    = data[LEVEL_CFG_W-1:0];
            REG_RELEASE_LEVEL:      release_q    = data[LEVEL_CFG_W-1:0];
            REG_SMOOTHING_GAIN:     gain_q       = data[GAIN_W-1:0];
            REG_SAMPLES_TO_TRIGGER: to_trigger_q = data[COUNT_CFG_W-1:0];
            REG_SAMPLES_TO_RELEASE: to_release_q = data[COUNT_CFG_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // result side: back-pressure, with the odd long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : receiver
        int hold_left;
        int holds_done;

        hold_left       = 0;
        holds_done      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                // long stall so the pipeline fills and the input side backs up
                hold_left       = hold_left - 1;
                result_ch.ready = 1'b0;
            end
            else
                result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // checker: each result transaction against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        level_report_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (level_reports_due.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: unexpected result transaction raw_echo %0d smoothed_level %0d",
                         $time, result_ch.raw_echo, result_ch.smoothed_level);
            end
            else
            begin
                want = level_reports_due.pop_front();
                if (result_ch.raw_echo !== want.raw)
                begin
                    errors = errors + 1;
                    $display("%0t: raw_echo expected %0d actual %0d",
                             $time, want.raw, result_ch.raw_echo);
                end
                if (result_ch.smoothed_level !== want.level)
                begin
                    errors = errors + 1;
                    $display("%0t: smoothed_level expected %0d actual %0d",
                             $time, want.level, result_ch.smoothed_level);
                end
                if (result_ch.active !== want.active)
                begin
                    errors = errors + 1;
                    $display("%0t: active expected %0d actual %0d",
                             $time, want.active, result_ch.active);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0]  bits;
        logic [LEVEL_CFG_W-1:0] trig;
        logic [LEVEL_CFG_W-1:0] rel;
        logic [GAIN_W-1:0]      gain;
        logic [COUNT_CFG_W-1:0] n_trig;
        logic [COUNT_CFG_W-1:0] n_rel;
        logic [SB-1:0]          s;
        int lo;
        int hi;
        int used;
        int r;
        int burst_len;
        int cls;

        item_ch.valid  = 1'b0;
        item_ch.kind   = KIND_SAMPLE;
        item_ch.sample = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_TRIGGER_LEVEL;
        cfg_wdata      = '0;
        rst_n          = 1'b0;
        reset_envelope();

        // hand-checked rows assume gain one, so the level is just the sample in q12.8
        directed_rows = '{
            item_row(KIND_SAMPLE, 12'd4095),            // sample while stopped
            item_row(KIND_UNKNOWN, 12'hABC),            // unknown kind
            item_row(KIND_START, 12'd0),
            checked_row(12'd0, 20'd0, 1'b0),            // zero stays zero at reset gain
            item_row(KIND_SAMPLE, 12'd4095),
            write_row(REG_SMOOTHING_GAIN, GAIN_ONE),
            checked_row(12'd4095, 20'hFFF00, 1'b0),     // first sample above trigger
            checked_row(12'd4095, 20'hFFF00, 1'b1),     // second one sets the flag
            checked_row(12'd2000, 20'd512000, 1'b1),    // band between thresholds
            checked_row(12'd0, 20'd0, 1'b1),
            checked_row(12'd0, 20'd0, 1'b1),
            checked_row(12'd0, 20'd0, 1'b0),            // third below clears the flag
            item_row(KIND_START, 12'd0),
            checked_row(12'd4095, 20'hFFF00, 1'b0),
            checked_row(12'd4095, 20'hFFF00, 1'b1),
            item_row(KIND_START, 12'hFFF),              // start while running
            checked_row(12'd4095, 20'hFFF00, 1'b0),
            item_row(KIND_STOP, 12'd0),
            item_row(KIND_SAMPLE, 12'd100),
            item_row(KIND_UNKNOWN, 12'hFFF),
            write_row(REG_SMOOTHING_GAIN, 16'hFFFF),    // gain above one
            write_row(REG_SAMPLES_TO_TRIGGER, 16'hFF00),
            write_row(REG_SAMPLES_TO_RELEASE, 16'hFF00),
            write_row(REG_SPARE_LO, 16'hFFFF),          // unused register slots
            write_row(REG_SPARE_HI, 16'hFFFF),
            item_row(KIND_START, 12'd0),
            checked_row(12'd3000, 20'd768000, 1'b1),    // zero run length sets at once
            checked_row(12'd0, 20'd0, 1'b0),
            checked_row(12'd0, 20'd0, 1'b1),
            write_row(REG_TRIGGER_LEVEL, 16'hFFFF),
            write_row(REG_RELEASE_LEVEL, 16'hF000),
            item_row(KIND_SAMPLE, 12'd4095),
            item_row(KIND_SAMPLE, 12'd2048),
            item_row(KIND_STOP, 12'd0)
        };

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                drain_results();
                write_register(directed_rows[i].idx, directed_rows[i].data);
            end
            else
                send_item(directed_rows[i].kind, directed_rows[i].sample,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();

            // settings for this phase, the first three at the extremes
            case (phase)
                0:
                begin
                    trig = '1; rel = '0; gain = GAIN_ONE; n_trig = '1; n_rel = '1;
                end
                1:
                begin
                    trig = '0; rel = '1; gain = '1; n_trig = '0; n_rel = 8'd1;
                end
                2:
                begin
                    trig   = LEVEL_CFG_W'($urandom_range(4095, 1000));
                    rel    = LEVEL_CFG_W'($urandom_range(trig, 0));
                    gain   = '0;
                    n_trig = 8'd1;
                    n_rel  = '0;
                end
                default:
                begin
                    trig = LEVEL_CFG_W'($urandom_range(4095, 800));
                    rel  = LEVEL_CFG_W'($urandom_range(trig, 0));
                    r    = $urandom_range(99);
                    if (r < 30)
                        gain = GAIN_W'($urandom_range(2000, 1));
                    else if (r < 60)
                        gain = GAIN_W'($urandom_range(32768, 2000));
                    else if (r < 75)
                        gain = GAIN_ONE;
                    else
                        gain = GAIN_W'($urandom_range(65535, 32769));
                    n_trig = COUNT_CFG_W'(($urandom_range(99) < 80) ? $urandom_range(6, 0)
                                                                    : $urandom_range(255, 7));
                    n_rel  = COUNT_CFG_W'(($urandom_range(99) < 80) ? $urandom_range(6, 0)
                                                                    : $urandom_range(255, 7));
                end
            endcase

            // unused upper bits of the write data get random values
            bits = CFG_DATA_W'($urandom);
            bits[LEVEL_CFG_W-1:0] = trig;
            write_register(REG_TRIGGER_LEVEL, bits);
            bits = CFG_DATA_W'($urandom);
            bits[LEVEL_CFG_W-1:0] = rel;
            write_register(REG_RELEASE_LEVEL, bits);
            write_register(REG_SMOOTHING_GAIN, gain);
            bits = CFG_DATA_W'($urandom);
            bits[COUNT_CFG_W-1:0] = n_trig;
            write_register(REG_SAMPLES_TO_TRIGGER, bits);
            bits = CFG_DATA_W'($urandom);
            bits[COUNT_CFG_W-1:0] = n_rel;
            write_register(REG_SAMPLES_TO_RELEASE, bits);

            // idling: none, sender, receiver, both lightly
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if (phase == 4)
                hold_requests = hold_requests + 1;

            lo = (trig < rel) ? int'(trig) : int'(rel);
            hi = (trig < rel) ? int'(rel) : int'(trig);
            used = 0;
            while (used < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (!running_q)
                begin
                    // mostly get going again, sometimes poke it while stopped
                    if (r < 75)
                        send_item(KIND_START, SB'($urandom), 1'b0, '0);
                    else if (r < 90)
                        send_item(KIND_SAMPLE, SB'($urandom), 1'b0, '0);
                    else
                        send_item(KIND_UNKNOWN, SB'($urandom), 1'b0, '0);
                    if (r < 75)
                        used = used + 1;
                end
                else if (r < 4)
                begin
                    send_item(KIND_STOP, SB'($urandom), 1'b0, '0);
                    used = used + 1;
                end
                else if (r < 7)
                begin
                    send_item(KIND_START, SB'($urandom), 1'b0, '0);
                    used = used + 1;
                end
                else if (r < 10)
                    send_item(KIND_UNKNOWN, SB'($urandom), 1'b0, '0);
                else
                begin
                    // burst of samples from one region, now and then long enough
                    // to saturate the run counters
                    r = $urandom_range(99);
                    if (r < 60)
                        burst_len = $urandom_range(16, 1);
                    else if (r < 90)
                        burst_len = $urandom_range(64, 16);
                    else
                        burst_len = $urandom_range(300, 200);
                    cls = $urandom_range(99);
                    repeat (burst_len)
                    begin
                        if (cls < 20)
                            s = ($urandom_range(1) == 0) ? 12'd4095
                                                          : SB'($urandom_range(4095, 4000));
                        else if (cls < 40)
                            s = SB'($urandom_range(4095, hi));
                        else if (cls < 60)
                            s = SB'($urandom_range(lo, 0));
                        else if (cls < 70)
                            s = '0;
                        else if (cls < 85)
                            s = SB'($urandom_range(hi, lo));
                        else
                            s = SB'($urandom);
                        send_item(KIND_SAMPLE, s, 1'b0, '0);
                        used = used + 1;
                    end
                end
            end
        end

        drain_results();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
